// ===== hw/rtl/pbs_pkg.sv =====
package pbs_pkg;

  localparam int PIX_W      = 16;
  localparam int DIM_W      = 13;
  localparam int POS_W      = 12;
  localparam int BIN_W      = 6;
  localparam int IN_BIN_W   = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int MAX_BIN    = 32;
  localparam int MAX_DIM    = 4096;
  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W     = $clog2(STORE_DEPTH);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int DIV_STEPS  = DIM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  localparam logic [PIX_W-1:0] PIX_SAT = {PIX_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIN_FACTOR = 2'd0,
    REG_FRAME_ROWS = 2'd1,
    REG_FRAME_COLS = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] used_rows;
    logic [DIM_W-1:0] used_cols;
    logic             busy;
  } geom_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic [ADDR_W-1:0] addr;
    logic              first;
    logic              emit;
    logic              last;
  } op_t;

  function automatic logic [BIN_W-1:0] clamp_bin(input logic [BIN_W-1:0] v);
    logic [BIN_W-1:0] r;
    r = v;
    if (v == '0) r = BIN_W'(1);
    else if (v > BIN_W'(MAX_BIN)) r = BIN_W'(MAX_BIN);
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    return r;
  endfunction

endpackage

// ===== hw/rtl/pixel_binning_saturating_core.sv =====
// A binned value passes from the transaction that carries the last pixel of its block
// through the op queue, the accumulate stage and the output register to the output.
// Throughput: one pixel per cycle while not held off, set by the accumulator store's single
// read-modify-write. A configuration write holds off input while the usable size is rebuilt.
// Reset clears the position counters and restores bin factor 1 and a 4096 by 4096 frame;
// the accumulator store is not cleared, since every block starts by overwriting its entry.
module pixel_binning_saturating_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [pbs_pkg::PIX_W-1:0]          s_axis_tdata,  // pixel
  input  logic                               s_axis_tuser,  // frame_start
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [pbs_pkg::PIX_W-1:0]          m_axis_tdata,  // binned_value
  output logic                               m_axis_tlast,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pbs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pbs_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import pbs_pkg::*;

  geom_t geom;
  op_t   push_op, head_op;
  logic  push, full, pop, empty;

  pbs_geom u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .geom_o      (geom)
  );

  pbs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .geom_i        (geom),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .full_i        (full),
    .push_o        (push),
    .op_o          (push_op)
  );

  pbs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head_op)
  );

  pbs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head_op),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== hw/rtl/pbs_geom.sv =====
module pbs_geom (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pbs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pbs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output pbs_pkg::geom_t                  geom_o
);
  import pbs_pkg::*;

  logic [BIN_W-1:0]     bin_q, bin_d;
  logic [DIM_W-1:0]     rows_q, rows_d, cols_q, cols_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIM_W-1:0]     sh_r_q, sh_r_d, sh_c_q, sh_c_d;
  logic [BIN_W-1:0]     rem_r_q, rem_r_d, rem_c_q, rem_c_d;
  logic [BIN_W-1:0]     b_eff;
  logic [DIM_W-1:0]     rows_eff, cols_eff;

  function automatic logic [BIN_W-1:0] rem_step(input logic [BIN_W-1:0] rem,
                                                input logic msb,
                                                input logic [BIN_W-1:0] b);
    logic [BIN_W:0] t;
    t = {rem, msb};
    if (t >= {1'b0, b}) t = t - {1'b0, b};
    return t[BIN_W-1:0];
  endfunction

  assign cfg_ready_o = 1'b1;
  assign b_eff    = clamp_bin(bin_q);
  assign rows_eff = clamp_dim(rows_q);
  assign cols_eff = clamp_dim(cols_q);

  always_comb begin
    bin_d   = bin_q;
    rows_d  = rows_q;
    cols_d  = cols_q;
    cnt_d   = cnt_q;
    sh_r_d  = sh_r_q;
    sh_c_d  = sh_c_q;
    rem_r_d = rem_r_q;
    rem_c_d = rem_c_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_BIN_FACTOR: bin_d  = cfg_data_i[BIN_W-1:0];
        REG_FRAME_ROWS: rows_d = cfg_data_i[DIM_W-1:0];
        REG_FRAME_COLS: cols_d = cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
      // The remainders of both frame sizes by the bin factor are rebuilt bit by bit.
      cnt_d   = DIV_CNT_W'(DIV_STEPS);
      sh_r_d  = clamp_dim(rows_d);
      sh_c_d  = clamp_dim(cols_d);
      rem_r_d = '0;
      rem_c_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d   = cnt_q - DIV_CNT_W'(1);
      rem_r_d = rem_step(rem_r_q, sh_r_q[DIM_W-1], b_eff);
      rem_c_d = rem_step(rem_c_q, sh_c_q[DIM_W-1], b_eff);
      sh_r_d  = {sh_r_q[DIM_W-2:0], 1'b0};
      sh_c_d  = {sh_c_q[DIM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q   <= BIN_W'(1);
      rows_q  <= DIM_W'(MAX_DIM);
      cols_q  <= DIM_W'(MAX_DIM);
      cnt_q   <= '0;
      rem_r_q <= '0;
      rem_c_q <= '0;
    end else begin
      bin_q   <= bin_d;
      rows_q  <= rows_d;
      cols_q  <= cols_d;
      cnt_q   <= cnt_d;
      rem_r_q <= rem_r_d;
      rem_c_q <= rem_c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_r_q <= sh_r_d;
    sh_c_q <= sh_c_d;
  end

  assign geom_o.bin       = b_eff;
  assign geom_o.rows      = rows_eff;
  assign geom_o.cols      = cols_eff;
  assign geom_o.used_rows = rows_eff - DIM_W'(rem_r_q);
  assign geom_o.used_cols = cols_eff - DIM_W'(rem_c_q);
  assign geom_o.busy      = (cnt_q != '0);

endmodule

// ===== hw/rtl/pbs_front.sv =====
module pbs_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pbs_pkg::geom_t              geom_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [pbs_pkg::PIX_W-1:0]   s_axis_tdata,
  input  logic                        s_axis_tuser,
  input  logic                        full_i,
  output logic                        push_o,
  output pbs_pkg::op_t                op_o
);
  import pbs_pkg::*;

  logic [POS_W-1:0]    row_q, row_d, col_q, col_d, orow_q, orow_d;
  logic [IN_BIN_W-1:0] rib_q, rib_d, cib_q, cib_d;
  logic [POS_W-1:0]    row_c, col_c, orow_c;
  logic [IN_BIN_W-1:0] rib_c, cib_c;
  logic [DIM_W-1:0]    row_nx, col_nx;
  logic [BIN_W-1:0]    rib_nx, cib_nx;
  logic                accept, in_use;

  assign s_axis_tready = !geom_i.busy && !full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    row_c  = s_axis_tuser ? '0 : row_q;
    col_c  = s_axis_tuser ? '0 : col_q;
    orow_c = s_axis_tuser ? '0 : orow_q;
    rib_c  = s_axis_tuser ? '0 : rib_q;
    cib_c  = s_axis_tuser ? '0 : cib_q;
    row_nx = DIM_W'(row_c) + DIM_W'(1);
    col_nx = DIM_W'(col_c) + DIM_W'(1);
    rib_nx = BIN_W'(rib_c) + BIN_W'(1);
    cib_nx = BIN_W'(cib_c) + BIN_W'(1);

    in_use = (DIM_W'(row_c) < geom_i.used_rows) && (DIM_W'(col_c) < geom_i.used_cols);

    op_o.pixel = s_axis_tdata;
    op_o.addr  = orow_c;
    op_o.first = (rib_c == '0) && (cib_c == '0);
    op_o.emit  = (rib_nx == geom_i.bin) && (cib_nx == geom_i.bin);
    op_o.last  = (row_nx == geom_i.used_rows) && (col_nx == geom_i.used_cols);

    row_d  = row_q;
    col_d  = col_q;
    orow_d = orow_q;
    rib_d  = rib_q;
    cib_d  = cib_q;
    if (accept) begin
      if (row_nx >= geom_i.rows) begin
        row_d  = '0;
        rib_d  = '0;
        orow_d = '0;
        if (col_nx >= geom_i.cols) begin
          col_d = '0;
          cib_d = '0;
        end else begin
          col_d = col_nx[POS_W-1:0];
          cib_d = (cib_nx >= geom_i.bin) ? '0 : cib_nx[IN_BIN_W-1:0];
          rib_d = '0;
        end
        col_d = (col_nx >= geom_i.cols) ? '0 : col_nx[POS_W-1:0];
      end else begin
        row_d = row_nx[POS_W-1:0];
        col_d = col_c;
        cib_d = cib_c;
        if (rib_nx >= geom_i.bin) begin
          rib_d  = '0;
          orow_d = orow_c + POS_W'(1);
        end else begin
          rib_d  = rib_nx[IN_BIN_W-1:0];
          orow_d = orow_c;
        end
      end
    end
  end

  assign push_o = accept && in_use;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      orow_q <= '0;
      rib_q  <= '0;
      cib_q  <= '0;
    end else begin
      row_q  <= row_d;
      col_q  <= col_d;
      orow_q <= orow_d;
      rib_q  <= rib_d;
      cib_q  <= cib_d;
    end
  end

endmodule

// ===== hw/rtl/pbs_queue.sv =====
module pbs_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pbs_pkg::op_t  op_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output pbs_pkg::op_t  head_o
);
  import pbs_pkg::*;

  op_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_PTR_W:0]   cnt_q;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      if (do_pop) rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      if (do_push && !do_pop) cnt_q <= cnt_q + (FIFO_PTR_W+1)'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - (FIFO_PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= op_i;
  end

endmodule

// ===== hw/rtl/pbs_back.sv =====
module pbs_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       empty_i,
  input  pbs_pkg::op_t               head_i,
  output logic                       pop_o,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [pbs_pkg::PIX_W-1:0]  m_axis_tdata,
  output logic                       m_axis_tlast
);
  import pbs_pkg::*;

  logic [PIX_W-1:0] store_q [STORE_DEPTH];
  logic             a_valid_q;
  op_t              a_op_q;
  logic [PIX_W-1:0] rd_q, fwd_q, acc, sum;
  logic             fwd_hit_q, out_free, a_fire;
  logic [PIX_W:0]   wide_sum;
  logic             out_valid_q;
  logic [PIX_W-1:0] out_data_q;
  logic             out_last_q;

  assign out_free = !out_valid_q || m_axis_tready;
  assign a_fire   = a_valid_q && (!a_op_q.emit || out_free);
  assign pop_o    = !empty_i && (!a_valid_q || a_fire);

  always_comb begin
    acc      = a_op_q.first ? '0 : (fwd_hit_q ? fwd_q : rd_q);
    wide_sum = {1'b0, acc} + {1'b0, a_op_q.pixel};
    sum      = wide_sum[PIX_W] ? PIX_SAT : wide_sum[PIX_W-1:0];
  end

  // A read issued while the stage ahead writes the same row takes the written sum.
  always_ff @(posedge clk_i) begin
    if (a_fire) store_q[a_op_q.addr] <= sum;
    if (pop_o) begin
      rd_q      <= store_q[head_i.addr];
      a_op_q    <= head_i;
      fwd_hit_q <= a_fire && (a_op_q.addr == head_i.addr);
      fwd_q     <= sum;
    end
    if (a_fire && a_op_q.emit) begin
      out_data_q <= sum;
      out_last_q <= a_op_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) a_valid_q <= 1'b1;
      else if (a_fire) a_valid_q <= 1'b0;
      if (a_fire && a_op_q.emit) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== hw/rtl/pbs_checker.sv =====
module pbs_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [pbs_pkg::PIX_W-1:0]  m_axis_tdata,
  input logic                       m_axis_tlast,
  input logic                       cfg_valid_i,
  input logic                       cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("Stalled output transaction changed.");

  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> !s_axis_tready)
    else $error("Input accepted right after a configuration write.");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("Configuration port not ready.");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("Output valid during reset.");

endmodule

bind pixel_binning_saturating_core pbs_checker u_pbs_checker (.*);
